FILE: design/vertex_weld_hash_table_core_macros.svh
// ----------------------------------------------------------------------------
// Vertex weld hash table assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_WELD_HASH_TABLE_CORE_MACROS_SVH
`define VERTEX_WELD_HASH_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VWHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vwht check failed");
// next-cycle implication
`define VWHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vwht check failed");
`else
`define VWHT_ASSERT_NOW(label, ante, cons)
`define VWHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/vwht_pkg.sv
// ----------------------------------------------------------------------------
// Vertex weld hash table package
// Sizes, codes, shared types and the hash and match helpers.
// ----------------------------------------------------------------------------
package vwht_pkg;

    localparam int MAX_VERTICES    = 4096;
    localparam int MAX_BUCKET_BITS = 12;
    localparam int BUCKETS         = 1 << MAX_BUCKET_BITS;
    localparam int IDX_W           = $clog2(MAX_VERTICES);
    localparam int BKT_W           = MAX_BUCKET_BITS;
    localparam int CNT_W           = IDX_W + 1;
    localparam int COORD_W         = 32;
    localparam int TOL_W           = 17;
    localparam int BB_W            = 4;
    localparam int BB_MIN          = 2;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);
    localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(MAX_BUCKET_BITS);

    localparam int HASH_ROUNDS = 9;
    localparam int ROUND_W     = $clog2(HASH_ROUNDS);
    localparam int HASH_SHL    = 5;
    localparam int HASH_SHR    = 27;
    localparam logic [COORD_W-1:0] HASH_ADD = 32'h1234_5678;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_MATCHED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_MISS     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // register indexes (word address)
    localparam logic REG_TOL   = 1'b0;
    localparam logic REG_BBITS = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_head;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        t_head                     link;
    } t_vertex;

    typedef struct packed {
        logic busy;
        logic done;
    } t_hash_status;

    // one mixing round: add constant plus shift-or with sign-filling right shift
    function automatic logic [COORD_W-1:0] mix_round(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] sra;
        sra = COORD_W'($signed(v) >>> HASH_SHR);
        return v + HASH_ADD + ((v << HASH_SHL) | sra);
    endfunction

    // |a - b| < tol, exact: -tol < a - b < tol
    function automatic logic near_axis(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b,
                                       input logic [TOL_W-1:0] tol);
        logic signed [COORD_W+1:0] d_lo;
        logic signed [COORD_W+1:0] d_hi;
        logic signed [COORD_W+1:0] t;
        t    = $signed({{(COORD_W+2-TOL_W){1'b0}}, tol});
        d_lo = (COORD_W+2)'(a) - (COORD_W+2)'(b) - t;
        d_hi = (COORD_W+2)'(a) - (COORD_W+2)'(b) + t;
        return d_lo[COORD_W+1] && !d_hi[COORD_W+1] && (d_hi != '0);
    endfunction

endpackage

FILE: design/vwht_hash.sv
// ----------------------------------------------------------------------------
// Vertex weld hash unit
// Three coordinate lanes mixed one round per cycle; result is their XOR.
// ----------------------------------------------------------------------------
module vwht_hash import vwht_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    output logic [COORD_W-1:0]        o_hash,
    output t_hash_status              o_status
);

    logic [COORD_W-1:0] r_lane_x;
    logic [COORD_W-1:0] r_lane_y;
    logic [COORD_W-1:0] r_lane_z;
    logic [ROUND_W-1:0] r_round;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                if (r_round == ROUND_W'(HASH_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lane_x <= i_coord_x;
            r_lane_y <= i_coord_y;
            r_lane_z <= i_coord_z;
        end else if (r_busy) begin
            r_lane_x <= mix_round(r_lane_x);
            r_lane_y <= mix_round(r_lane_y);
            r_lane_z <= mix_round(r_lane_z);
        end
    end

    assign o_hash   = r_lane_x ^ r_lane_y ^ r_lane_z;
    assign o_status = '{busy: r_busy, done: r_done};

endmodule

FILE: design/vertex_weld_hash_table_core.sv
// ----------------------------------------------------------------------------
// Vertex weld hash table core
// Deduplicates 16.16 vertices through a chained hash table held in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries op and the x, y, z
//   coordinates; output channel (o_out_valid / i_out_stall) returns the vertex
//   index and a status per transaction. A transaction moves at a clock edge
//   where valid is high and stall is low.
//   After an input is accepted the core runs nine hash rounds, one per cycle,
//   then reads one chain entry from RAM per step until a match or the end of
//   the chain. No new input is taken until the result has been loaded into
//   the output register.
//   The output register holds a finished result while the next input is taken;
//   if the receiver stalls, the core finishes its item and waits for the
//   register to empty before taking another.
//   After reset the bucket head RAM is swept clear, one bucket per cycle, over
//   all 4096 buckets; o_in_stall stays high meanwhile. Configuration writes on the
//   APB port are accepted at any time but must be made while the core is idle.
//   Registers: 0x0 tolerance (17 bits), 0x4 bucket bits (saturated to 2..12).
// ----------------------------------------------------------------------------
`include "vertex_weld_hash_table_core_macros.svh"

module vertex_weld_hash_table_core import vwht_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [IDX_W-1:0]          o_vertex_index,
    output logic [1:0]                o_status,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_MISS  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // state and control
    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [BKT_W-1:0]    r_clr_addr;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic [1:0]          r_res_status, n_res_status;

    // configuration
    logic [TOL_W-1:0]    r_tol;
    logic [BB_W-1:0]     r_bbits;
    logic [BB_W-1:0]     w_bb_sat;
    logic                w_reg_idx;

    // latched item
    logic                      r_op;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;

    // output register
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [1:0]          r_out_status;

    // memories
    t_head               head_mem [BUCKETS];
    t_vertex             store_mem [MAX_VERTICES];
    t_head               r_head_rd;
    t_vertex             r_st_rd;

    logic [COORD_W-1:0]  w_hash;
    t_hash_status        w_hash_st;
    logic [BKT_W-1:0]    w_mask;
    logic [BKT_W-1:0]    w_bucket;
    logic                w_accept;
    logic                w_match;
    logic [CNT_W-1:0]    w_steps_nx;
    logic                w_full;
    logic                w_ins;
    logic                w_out_load;
    logic                w_head_we;
    logic [BKT_W-1:0]    w_head_waddr;
    t_head               w_head_wdata;
    logic [IDX_W-1:0]    w_st_raddr;

    vwht_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_coord_z (i_coord_z),
        .o_hash    (w_hash),
        .o_status  (w_hash_st)
    );

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign w_mask     = ~({BKT_W{1'b1}} << r_bbits);
    assign w_bucket   = w_hash[BKT_W-1:0] & w_mask;

    assign w_match    = near_axis(r_st_rd.x, r_x, r_tol) &&
                        near_axis(r_st_rd.y, r_y, r_tol) &&
                        near_axis(r_st_rd.z, r_z, r_tol);
    assign w_steps_nx = r_steps + 1'b1;
    assign w_full     = (r_count == CNT_W'(MAX_VERTICES));
    assign w_ins      = (r_state == S_MISS) && (r_op == OP_INSERT) && !w_full;
    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign w_head_we    = (r_state == S_CLEAR) || w_ins;
    assign w_head_waddr = (r_state == S_CLEAR) ? r_clr_addr : w_bucket;
    assign w_head_wdata = (r_state == S_CLEAR) ? '0 :
                          t_head'{valid: 1'b1, idx: r_count[IDX_W-1:0]};
    assign w_st_raddr   = (r_state == S_HEAD) ? r_head_rd.idx : r_st_rd.link.idx;

    // bucket head RAM: read every cycle at the current hash bucket
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            head_mem[w_head_waddr] <= w_head_wdata;
        end
        r_head_rd <= head_mem[w_bucket];
    end

    // vertex store RAM: new vertex is prepended to its bucket chain
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            store_mem[r_count[IDX_W-1:0]] <= t_vertex'{x: r_x, y: r_y, z: r_z,
                                                       link: r_head_rd};
        end
        r_st_rd <= store_mem[w_st_raddr];
    end

    always_comb begin
        n_state      = r_state;
        n_steps      = r_steps;
        n_cur        = r_cur;
        n_res_idx    = r_res_idx;
        n_res_status = r_res_status;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_st.done) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_steps = '0;
                n_cur   = r_head_rd.idx;
                if (r_head_rd.valid && (r_count != '0)) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_WALK: begin
                if (w_match) begin
                    n_res_idx    = r_cur;
                    n_res_status = ST_MATCHED;
                    n_state      = S_EMIT;
                end else begin
                    // advance along the chain, bounded by the stored count
                    n_steps = w_steps_nx;
                    n_cur   = r_st_rd.link.idx;
                    if (!(r_st_rd.link.valid && (w_steps_nx < r_count))) begin
                        n_state = S_MISS;
                    end
                end
            end
            S_MISS: begin
                n_state = S_EMIT;
                if (r_op == OP_LOOKUP) begin
                    n_res_idx    = '0;
                    n_res_status = ST_MISS;
                end else if (w_full) begin
                    n_res_idx    = '0;
                    n_res_status = ST_FULL;
                end else begin
                    n_res_idx    = r_count[IDX_W-1:0];
                    n_res_status = ST_INSERTED;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps      <= n_steps;
        r_cur        <= n_cur;
        r_res_idx    <= n_res_idx;
        r_res_status <= n_res_status;
        if (w_accept) begin
            r_op <= i_op;
            r_x  <= i_coord_x;
            r_y  <= i_coord_y;
            r_z  <= i_coord_z;
        end
        if (w_out_load) begin
            r_out_idx    <= r_res_idx;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_out_idx;
    assign o_status       = r_out_status;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];

    always_comb begin
        w_bb_sat = pwdata[BB_W-1:0];
        if (w_bb_sat < BB_W'(BB_MIN)) begin
            w_bb_sat = BB_W'(BB_MIN);
        end else if (w_bb_sat > BB_W'(MAX_BUCKET_BITS)) begin
            w_bb_sat = BB_W'(MAX_BUCKET_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_bbits <= BB_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_TOL:   r_tol   <= pwdata[TOL_W-1:0];
                REG_BBITS: r_bbits <= w_bb_sat;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TOL:   prdata = {{(DATA_W-TOL_W){1'b0}}, r_tol};
            REG_BBITS: prdata = {{(DATA_W-BB_W){1'b0}}, r_bbits};
        endcase
    end

    // checks
    `VWHT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_VERTICES))
    `VWHT_ASSERT_NEXT(a_insert_count, w_ins, r_count == $past(r_count) + 1'b1)
    `VWHT_ASSERT_NOW(a_walk_bound, r_state == S_WALK, r_steps < r_count)
    `VWHT_ASSERT_NOW(a_hash_live, r_state == S_HASH, w_hash_st.busy || w_hash_st.done)
    `VWHT_ASSERT_NOW(a_out_from_emit, r_out_valid && !$past(r_out_valid),
                     $past(r_state) == S_EMIT)

endmodule
